// ----- src/hierarchical_bitmap_id_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap ID allocator
// Short forms for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HIERARCHICAL_BITMAP_ID_ALLOCATOR_ASSERT_SVH
`define HIERARCHICAL_BITMAP_ID_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define HBA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked during reset as well.
`define HBA_ASSERT_NXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/hba_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap ID allocator package
// Tree geometry, word types, command and status codes, and helpers that
// locate a tree node and pick bits out of a byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hba_pkg;

   // Tree geometry.
   localparam int LEVELS     = 4;
   localparam int ID_W       = 3 * LEVELS;
   localparam int STORE_SIZE = ((8 ** LEVELS) - 1) / 7;
   localparam int ADDR_W     = $clog2(STORE_SIZE);
   localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   // Port field widths.
   localparam int REQ_ID_W = 12;
   localparam int STATUS_W = 2;

   // Request actions.
   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   // Command kinds handed from the front end to the engine.
   localparam logic [1:0] CMD_ALLOC  = 2'd0;
   localparam logic [1:0] CMD_FREE   = 2'd1;
   localparam logic [1:0] CMD_REJECT = 2'd2;

   typedef struct packed {
      logic                action;
      logic [REQ_ID_W-1:0] free_id;
   } req_type;

   typedef struct packed {
      logic [REQ_ID_W-1:0] given_id;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [1:0]      kind;
      logic [ID_W-1:0] id;
   } cmd_type;

   // Head of the command queue as seen by the engine.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   // Engine feedback to the front end.
   typedef struct packed {
      logic pop;
      logic clearing;
   } engine_status_type;

   // Position of the first clear bit, MSB first; 8 when the byte is full.
   function automatic logic [3:0] first_clear(input logic [7:0] b);
      logic [3:0] pos;
      pos = 4'd8;
      for (int i = 7; i >= 0; i--) begin
         if (!b[7-i]) begin
            pos = 4'(i);
         end
      end
      return pos;
   endfunction

   // Store address of the node on the path of id at the given level.
   function automatic logic [ADDR_W-1:0] node_addr(input logic [ID_W-1:0] id,
                                                   input logic [LVL_W-1:0] lvl);
      logic [ADDR_W-1:0] off;
      logic [ID_W-1:0]   node;
      off  = '0;
      node = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (LVL_W'(i) == lvl) begin
            node = id >> (3 * (LEVELS - i));
         end
         if (LVL_W'(i) < lvl) begin
            off = ADDR_W'({off, 3'b000}) + ADDR_W'(1);
         end
      end
      return off + ADDR_W'(node);
   endfunction

   // Child digit of id below the node at the given level.
   function automatic logic [2:0] digit_of(input logic [ID_W-1:0] id,
                                           input logic [LVL_W-1:0] lvl);
      logic [2:0] dig;
      dig = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (LVL_W'(i) == lvl) begin
            dig = 3'(id >> (3 * (LEVELS - 1 - i)));
         end
      end
      return dig;
   endfunction

   // Insert a digit into id at the given level.
   function automatic logic [ID_W-1:0] place_digit(input logic [ID_W-1:0] id,
                                                   input logic [LVL_W-1:0] lvl,
                                                   input logic [2:0] dig);
      logic [ID_W-1:0] res;
      res = id;
      for (int i = 0; i < LEVELS; i++) begin
         if (LVL_W'(i) == lvl) begin
            res = id | (ID_W'(dig) << (3 * (LEVELS - 1 - i)));
         end
      end
      return res;
   endfunction

endpackage

// ----- src/hba_front.sv -----
// ----------------------------------------------------------------------------
// Allocator front end
// Accepts request words, classifies them into commands and holds them in a
// two-entry queue for the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hba_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  hba_pkg::req_type           req_data,
   input  hba_pkg::engine_status_type eng_status,
   output hba_pkg::queue_head_type    head
);
   import hba_pkg::*;

   cmd_type    queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       out_of_range;
   cmd_type    new_cmd;

   // Hold off requests while the queue is full or the store is clearing.
   assign busy = (count_ff == 2'd2) || eng_status.clearing;
   assign push = start && !busy;

   // Classify the request word.
   always_comb begin
      out_of_range = (REQ_ID_W'(req_data.free_id >> ID_W) != '0);
      new_cmd.id   = ID_W'(req_data.free_id);
      priority if (req_data.action == ACTION_ALLOC) begin
         new_cmd.kind = CMD_ALLOC;
         new_cmd.id   = '0;
      end else if (out_of_range) begin
         new_cmd.kind = CMD_REJECT;
      end else begin
         new_cmd.kind = CMD_FREE;
      end
   end

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ eng_status.pop;
      count_in  = count_ff + 2'(push) - 2'(eng_status.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = queue_ff[rd_ptr_ff];

endmodule

// ----- src/hba_engine.sv -----
// ----------------------------------------------------------------------------
// Allocator engine
// Owns the full-mark store. Clears it after reset, then walks each allocate
// or free down the tree reading one byte per level and back up writing one
// byte per level, and drives the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hba_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  hba_pkg::queue_head_type    head,
   output hba_pkg::engine_status_type eng_status,
   output logic                       rsp_strobe,
   output hba_pkg::rsp_type           rsp_data
);
   import hba_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_DOWN  = 2'd2;
   localparam logic [1:0] ST_UP    = 2'd3;

   logic [7:0]        mem [STORE_SIZE];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [1:0]        kind_ff, kind_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic              child_full_ff, child_full_in;
   logic [7:0]        path_ff [LEVELS];
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              is_alloc;
   logic [3:0]        fc;
   logic [ID_W-1:0]   id_next;
   logic [2:0]        dig;
   logic [7:0]        mask;
   logic              set_bit;
   logic [7:0]        new_byte;

   assign is_alloc = (kind_ff == CMD_ALLOC);

   // Store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Remember the bytes read on the way down for the walk back up.
   always_ff @(posedge clock) begin
      if (state_ff == ST_DOWN) begin
         path_ff[lvl_ff] <= rd_data_ff;
      end
   end

   // Walk sequencing.
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      kind_in       = kind_ff;
      id_in         = id_ff;
      lvl_in        = lvl_ff;
      child_full_in = child_full_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = clr_addr_ff;
      wr_data       = '0;
      eng_status    = '0;

      fc       = first_clear(rd_data_ff);
      id_next  = is_alloc ? place_digit(id_ff, lvl_ff, fc[2:0]) : id_ff;
      dig      = digit_of(id_ff, lvl_ff);
      mask     = 8'h80 >> dig;
      set_bit  = (lvl_ff == LVL_W'(LEVELS - 1)) ? is_alloc : child_full_ff;
      new_byte = set_bit ? (path_ff[lvl_ff] | mask) : (path_ff[lvl_ff] & ~mask);

      eng_status.clearing = (state_ff == ST_CLEAR);

      unique case (state_ff)
         // Sweep zeros through the store after reset.
         ST_CLEAR: begin
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(STORE_SIZE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         // Take the next command; a rejected free answers at once.
         ST_IDLE: begin
            if (head.valid) begin
               eng_status.pop = 1'b1;
               kind_in        = head.cmd.kind;
               if (head.cmd.kind == CMD_REJECT) begin
                  rsp_strobe_in        = 1'b1;
                  rsp_data_in.given_id = '0;
                  rsp_data_in.status   = STATUS_RANGE;
               end else begin
                  id_in    = head.cmd.id;
                  lvl_in   = '0;
                  state_in = ST_DOWN;
               end
            end
         end
         // Byte of level lvl is in the read register.
         ST_DOWN: begin
            if (is_alloc && fc[3]) begin
               rsp_strobe_in        = 1'b1;
               rsp_data_in.given_id = '0;
               rsp_data_in.status   = STATUS_FULL;
               state_in             = ST_IDLE;
            end else begin
               id_in = id_next;
               if (lvl_ff == LVL_W'(LEVELS - 1)) begin
                  state_in = ST_UP;
               end else begin
                  lvl_in  = lvl_ff + LVL_W'(1);
                  rd_addr = node_addr(id_next, LVL_W'(lvl_ff + LVL_W'(1)));
               end
            end
         end
         // Update one byte per level from the leaf to the root.
         ST_UP: begin
            wr_en         = 1'b1;
            wr_addr       = node_addr(id_ff, lvl_ff);
            wr_data       = new_byte;
            child_full_in = (new_byte == 8'hff);
            if (lvl_ff == '0) begin
               rsp_strobe_in        = 1'b1;
               rsp_data_in.given_id = is_alloc ? REQ_ID_W'(id_ff) : '0;
               rsp_data_in.status   = STATUS_OK;
               state_in             = ST_IDLE;
            end else begin
               lvl_in = lvl_ff - LVL_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      lvl_ff        <= lvl_in;
      child_full_ff <= child_full_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ----- src/hierarchical_bitmap_id_allocator.sv -----
// ----------------------------------------------------------------------------
// Hierarchical bitmap ID allocator
// Hands out the lowest free ID of 8^LEVELS and takes IDs back, using an
// 8-ary tree of full-mark bytes.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low. Every request
// produces exactly one result word, shown for one cycle with rsp_strobe high;
// the receiver cannot stall it, so it must take the word in that cycle.
// Results come back in request order. An allocate or free walks the store
// down and back up, one byte access per level; an allocate on a full tree
// ends as soon as the full root is seen, and a free of an out-of-range ID
// answers without a walk. Each level's read depends on the byte read at the
// level above, and this level-by-level walk sets the pace. A two-word queue
// lets requests be taken while the engine works. After reset the store is
// zeroed one byte per cycle, which holds busy high until all 585 bytes at
// LEVELS = 4 are written.
`timescale 1ns / 1ps

module hierarchical_bitmap_id_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hba_pkg::req_type req_data,
   output logic             rsp_strobe,
   output hba_pkg::rsp_type rsp_data
);
   import hba_pkg::*;

   queue_head_type    head;
   engine_status_type eng_status;

   // Request intake and command queue.
   hba_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .eng_status (eng_status),
      .head       (head)
   );

   // Tree walk and store.
   hba_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .eng_status (eng_status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- src/hba_checker.sv -----
// ----------------------------------------------------------------------------
// Allocator port checker
// Watches the top-level ports for result codes and reset behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "hierarchical_bitmap_id_allocator_assert.svh"

module hba_checker (
   input logic             clock,
   input logic             reset,
   input logic             busy,
   input logic             rsp_strobe,
   input hba_pkg::rsp_type rsp_data
);
   import hba_pkg::*;

   // A result word only carries a defined status code.
   `HBA_ASSERT_IMP(a_status_code, clock, reset, rsp_strobe, (rsp_data.status == STATUS_OK) || (rsp_data.status == STATUS_FULL) || (rsp_data.status == STATUS_RANGE), "undefined status code")

   // Failed requests and frees report ID zero.
   `HBA_ASSERT_IMP(a_fail_zero, clock, reset, rsp_strobe && (rsp_data.status != STATUS_OK), rsp_data.given_id == '0, "nonzero ID on a failed request")

   // Right after reset the store is being cleared and nothing is reported.
   `HBA_ASSERT_NXT(a_reset_busy, clock, reset, busy && !rsp_strobe, "not busy after reset")

endmodule

bind hierarchical_bitmap_id_allocator hba_checker u_checker (.*);
